// ===== src/svl_pkg.sv =====
// ----------------------------------------------------------------------------
// svl_pkg: shared definitions for the sorted unique value list
// Request and status codes, size defaults and the cell control struct.
// ----------------------------------------------------------------------------
package svl_pkg;

    localparam int unsigned CAPACITY_DEF    = 16;
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_DUP      = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // broadcast control, same for every cell
    typedef struct packed {
        logic ins;   // insert the broadcast value at its sorted place
        logic del;   // remove the matching entry, close the gap
    } t_cell_ctl;

endpackage

// ===== src/sorted_unique_value_list.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_value_list: bounded ascending set of signed values
// Insert or delete requests over a row of compare-and-shift cells; each
// request word returns one result word with status, count, head and tail.
// ----------------------------------------------------------------------------
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+----------------------------------
//  request  | i_in_valid   | o_in_ready   | i_req_type, i_value
//  result   | o_out_valid  | i_out_ready  | o_status, o_entry_count,
//           |              |              | o_is_empty, o_smallest_value,
//           |              |              | o_largest_value
//
//  One request word per cycle. The word is broadcast to every cell; each cell
//  compares, then holds, takes the value or takes a neighbour's entry, all in
//  the same cycle. The result is registered and shows the cycle after accept.
//  A new word is taken while the result register is empty or being emptied,
//  so with the result side ready the block runs at one word a cycle.
//  Synchronous active-low reset empties the list and the result register;
//  the cell entries need no reset as only slots below the count are read.
// ----------------------------------------------------------------------------
module sorted_unique_value_list #(
    parameter int unsigned CAPACITY    = svl_pkg::CAPACITY_DEF,
    parameter int unsigned VALUE_WIDTH = svl_pkg::VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [4:0]  o_entry_count,
    output logic        o_is_empty,
    output logic [31:0] o_smallest_value,
    output logic [31:0] o_largest_value
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // ------------------------------------------------------------------
    // list state
    // ------------------------------------------------------------------
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic                   accept;
    logic [VALUE_WIDTH-1:0] bvalue;
    svl_pkg::t_cell_ctl     ctl;
    logic                   found;
    logic                   full;
    logic [1:0]             status;

    logic [CAPACITY-1:0]    lt;
    logic [CAPACITY-1:0]    eq;
    logic [CAPACITY-1:0]    occupied;
    logic [VALUE_WIDTH-1:0] cur_val  [CAPACITY];
    logic [VALUE_WIDTH-1:0] next_val [CAPACITY];

    assign accept = i_in_valid && o_in_ready;

    // input value sign-extended or cut to the held width
    generate
        if (VALUE_WIDTH > 32) begin : g_in_ext
            assign bvalue = {{(VALUE_WIDTH - 32){i_value[31]}}, i_value};
        end else begin : g_in_cut
            assign bvalue = i_value[VALUE_WIDTH-1:0];
        end
    endgenerate

    assign found = |eq;
    assign full  = (r_count == CW'(CAPACITY));

    always_comb begin
        ctl     = '0;
        status  = svl_pkg::ST_DONE;
        n_count = r_count;
        unique case (i_req_type)
            svl_pkg::REQ_INSERT: begin
                if (found) begin
                    status = svl_pkg::ST_DUP;       // checked before fullness
                end else if (full) begin
                    status = svl_pkg::ST_FULL;
                end else begin
                    ctl.ins = accept;
                    n_count = r_count + CW'(1);
                end
            end
            svl_pkg::REQ_DELETE: begin
                if (found) begin
                    ctl.del = accept;
                    n_count = r_count - CW'(1);
                end else begin
                    status = svl_pkg::ST_NOTFOUND;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                   left_lt;
            logic [VALUE_WIDTH-1:0] left_value;
            logic [VALUE_WIDTH-1:0] right_value;

            assign occupied[gi] = (CW'(gi) < r_count);

            if (gi == 0) begin : g_first
                assign left_lt    = 1'b1;          // head slot takes the value
                assign left_value = bvalue;
            end else begin : g_mid
                assign left_lt    = lt[gi-1];
                assign left_value = cur_val[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_value = cur_val[gi];  // falls out of use
            end else begin : g_inner
                assign right_value = cur_val[gi+1];
            end

            svl_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_bvalue     (bvalue),
                .i_occupied   (occupied[gi]),
                .i_left_lt    (left_lt),
                .i_left_value (left_value),
                .i_right_value(right_value),
                .o_lt         (lt[gi]),
                .o_eq         (eq[gi]),
                .o_value      (cur_val[gi]),
                .o_next_value (next_val[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // head and tail of the list after this request
    // tail found by one-hot AND-OR over the cells
    // ------------------------------------------------------------------
    logic [CW-1:0]          tail_idx;
    logic [VALUE_WIDTH-1:0] tail_val;
    logic                   n_empty;

    assign tail_idx = n_count - CW'(1);
    assign n_empty  = (n_count == '0);

    always_comb begin
        tail_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (tail_idx == CW'(i)) begin
                tail_val = tail_val | next_val[i];
            end
        end
    end

    logic [31:0] head_out;
    logic [31:0] tail_out;

    generate
        if (VALUE_WIDTH >= 32) begin : g_out_cut
            assign head_out = next_val[0][31:0];
            assign tail_out = tail_val[31:0];
        end else begin : g_out_ext
            assign head_out = {{(32 - VALUE_WIDTH){next_val[0][VALUE_WIDTH-1]}}, next_val[0]};
            assign tail_out = {{(32 - VALUE_WIDTH){tail_val[VALUE_WIDTH-1]}}, tail_val};
        end
    endgenerate

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [4:0]  r_entry_count;
    logic        r_is_empty;
    logic [31:0] r_smallest;
    logic [31:0] r_largest;

    assign o_in_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= status;
            r_entry_count <= 5'(n_count);
            r_is_empty    <= n_empty;
            r_smallest    <= n_empty ? 32'd0 : head_out;
            r_largest     <= n_empty ? 32'd0 : tail_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_entry_count    = r_entry_count;
    assign o_is_empty       = r_is_empty;
    assign o_smallest_value = r_smallest;
    assign o_largest_value  = r_largest;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins |=> (r_count == $past(r_count) + CW'(1)) && o_status == svl_pkg::ST_DONE)
        else $error("insert did not grow the list");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == 5'd0)))
        else $error("empty flag disagrees with count");

    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_entry_count == 5'd1) |-> (o_smallest_value == o_largest_value))
        else $error("single entry with differing head and tail");

endmodule

// ===== src/svl_cell.sv =====
// ----------------------------------------------------------------------------
// svl_cell: one slot of the sorted list
// Compares its entry with the broadcast value and shifts up or down.
// ----------------------------------------------------------------------------
module svl_cell #(
    parameter int unsigned VALUE_WIDTH = svl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  svl_pkg::t_cell_ctl     i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_bvalue,     // broadcast value
    input  logic                   i_occupied,   // slot index below count
    input  logic                   i_left_lt,    // left neighbour below value
    input  logic [VALUE_WIDTH-1:0] i_left_value,
    input  logic [VALUE_WIDTH-1:0] i_right_value,
    output logic                   o_lt,
    output logic                   o_eq,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [VALUE_WIDTH-1:0] o_next_value
);

    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;

    assign o_lt = i_occupied && ($signed(r_value) < $signed(i_bvalue));
    assign o_eq = i_occupied && (r_value == i_bvalue);

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins && !o_lt) begin
            n_value = i_left_lt ? i_bvalue : i_left_value;
        end else if (i_ctl.del && !o_lt) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_next_value = n_value;

endmodule
